@@ sv/frx_pkg.sv @@
`timescale 1ns / 1ps

package frx_pkg;

	// Widths fixed by the byte stream and the event set.
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned EVENT_W = 3;
	localparam int unsigned CFG_IDX_W = 2;

	// Event codes reported with each result item.
	localparam logic [EVENT_W-1:0] EV_BUSY   = 3'd0;
	localparam logic [EVENT_W-1:0] EV_ACCEPT = 3'd1;
	localparam logic [EVENT_W-1:0] EV_CKERR  = 3'd2;
	localparam logic [EVENT_W-1:0] EV_ENDERR = 3'd3;
	localparam logic [EVENT_W-1:0] EV_READ   = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE     = 2'd2;

	// Action codes of an input item.
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// Result of one item as it leaves the controller.
	typedef struct packed {
		logic [EVENT_W-1:0] event_code;
		logic [BYTE_W-1:0]  frame_length;
		logic               read_ok;
	} frx_res_t;

endpackage

@@ sv/frx_store.sv @@
`timescale 1ns / 1ps

module frx_store import frx_pkg::*; #(
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned ADDR_W = 8
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	// Payload write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/frx_ctrl.sv @@
`timescale 1ns / 1ps

module frx_ctrl import frx_pkg::*; #(
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned ADDR_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 accept,
	input  logic                 action,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic [BYTE_W-1:0]    read_index,
	output logic                 wr_en,
	output logic [ADDR_W-1:0]    wr_addr,
	output logic [BYTE_W-1:0]    wr_data,
	output frx_res_t             res
);

	typedef enum logic [2:0] {
		PH_START1 = 3'd0,
		PH_START2 = 3'd1,
		PH_LEN    = 3'd2,
		PH_DATA   = 3'd3,
		PH_CHECK  = 3'd4,
		PH_END    = 3'd5
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] len_q, len_d;
	logic [BYTE_W-1:0] count_q, count_d;
	logic [BYTE_W-1:0] xor_q, xor_d;
	logic [BYTE_W-1:0] start_first_q, start_second_q, end_byte_q;
	logic [EVENT_W-1:0] ev;
	logic              count_in_store;
	logic              idx_in_store;

	assign count_in_store = {1'b0, count_q} < (BYTE_W+1)'(DEPTH);
	assign idx_in_store   = {1'b0, read_index} < (BYTE_W+1)'(DEPTH);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_first_q  <= '0;
			start_second_q <= '0;
			end_byte_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_FIRST:  start_first_q  <= cfg_data;
				CFG_START_SECOND: start_second_q <= cfg_data;
				CFG_END_BYTE:     end_byte_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame parser: next state and event for each item, a received byte or a read.
	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		count_d = count_q;
		xor_d   = xor_q;
		ev      = EV_BUSY;
		wr_en   = 1'b0;
		if (action == ACT_READ) begin
			ev = EV_READ;
		end else begin
			case (phase_q)
				PH_START1: begin
					if (rx_byte == start_first_q) phase_d = PH_START2;
				end
				PH_START2: begin
					// Anything but the second start byte keeps waiting here.
					if (rx_byte == start_second_q) phase_d = PH_LEN;
				end
				PH_LEN: begin
					len_d   = rx_byte;
					count_d = '0;
					xor_d   = '0;
					phase_d = PH_DATA;
				end
				PH_DATA: begin
					// Bytes past the store are still counted and folded in.
					wr_en   = accept && count_in_store;
					count_d = count_q + 1'b1;
					xor_d   = xor_q ^ rx_byte;
					if (count_d >= len_q) phase_d = PH_CHECK;
				end
				PH_CHECK: begin
					if (xor_q == rx_byte) begin
						phase_d = PH_END;
					end else begin
						phase_d = PH_START1;
						ev      = EV_CKERR;
					end
				end
				PH_END: begin
					ev      = (rx_byte == end_byte_q) ? EV_ACCEPT : EV_ENDERR;
					phase_d = PH_START1;
				end
				default: begin
					phase_d = PH_START1;
				end
			endcase
		end
	end

	// Parser state, updated once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START1;
			len_q   <= '0;
			count_q <= '0;
			xor_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			count_q <= count_d;
			xor_q   <= xor_d;
		end
	end

	assign wr_addr = count_q[ADDR_W-1:0];
	assign wr_data = rx_byte;

	// A read is answered only below the received count and inside the store.
	assign res.event_code   = ev;
	assign res.frame_length = len_d;
	assign res.read_ok      = (action == ACT_READ) && (read_index < count_q) && idx_in_store;

endmodule

@@ sv/framed_packet_receiver.sv @@
`timescale 1ns / 1ps

// Framed byte-stream receiver. Each input item is either a received byte or a
// read of the payload buffer, and each gives exactly one result item: an event
// code, the read byte (zero unless a valid read) and the current frame length.
// The block takes one item per clock while in_stall is low. Its result passes
// through stage one and then the output register before it reaches the output
// ports. The payload memory has one write port used by payload bytes and one
// registered read port used by read items. A skid stage in front of the output
// register lets one more item enter while a result waits on out_stall. Frames
// are a first start byte, a second start byte, a length byte, the payload, an
// XOR checksum and an end byte. The user must write the three marker values
// through the configuration port while idle; the block does not enforce this.
module framed_packet_receiver import frx_pkg::*; #(
	parameter int unsigned PAYLOAD_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic [BYTE_W-1:0]    read_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [EVENT_W-1:0]   event_code,
	output logic [BYTE_W-1:0]    read_data,
	output logic [BYTE_W-1:0]    frame_length
);

	localparam int unsigned ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	logic              accept;
	logic              advance;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic [BYTE_W-1:0] rd_data;
	frx_res_t          res;
	frx_res_t          res_s1;
	logic              valid_s1;
	logic              out_valid_q;
	logic [EVENT_W-1:0] event_code_q;
	logic [BYTE_W-1:0] read_data_q;
	logic [BYTE_W-1:0] frame_length_q;

	// Stage one moves on when the output register is empty or being taken.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	frx_ctrl #(
		.DEPTH (PAYLOAD_DEPTH),
		.ADDR_W(ADDR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.action    (action),
		.rx_byte   (rx_byte),
		.read_index(read_index),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.res       (res)
	);

	frx_store #(
		.DEPTH (PAYLOAD_DEPTH),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (accept),
		.rd_addr(read_index[ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	// Stage one: waits for the memory read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			event_code_q   <= res_s1.event_code;
			frame_length_q <= res_s1.frame_length;
			read_data_q    <= res_s1.read_ok ? rd_data : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_code   = event_code_q;
	assign read_data    = read_data_q;
	assign frame_length = frame_length_q;

endmodule

@@ sv/frx_checker.sv @@
`timescale 1ns / 1ps

module frx_checker import frx_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [EVENT_W-1:0] event_code,
	input logic [BYTE_W-1:0]  read_data,
	input logic [BYTE_W-1:0]  frame_length
);

	// Only the five defined events ever leave the block.
	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_code == EV_BUSY || event_code == EV_ACCEPT ||
			event_code == EV_CKERR || event_code == EV_ENDERR || event_code == EV_READ))
		else $error("event code outside the defined set");

	// Read data is zero on every item that is not a read.
	a_read_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_code != EV_READ) |-> (read_data == '0))
		else $error("read data nonzero on a non-read item");

	// The input backs up only behind a stalled output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled output");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(event_code) &&
			$stable(read_data) && $stable(frame_length)))
		else $error("stalled result changed");

endmodule

bind framed_packet_receiver frx_checker u_frx_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.event_code  (event_code),
	.read_data   (read_data),
	.frame_length(frame_length)
);
